/* src/bezier_curve_point_eval_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef BEZIER_CURVE_POINT_EVAL_ASSERT_SVH
`define BEZIER_CURVE_POINT_EVAL_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BCPE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcpe check failed");

// Next-cycle implication, off during reset.
`define BCPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcpe check failed");

`endif

/* src/bcpe_pkg.sv */
package bcpe_pkg;

  localparam int COORD_W = 16;
  localparam int T_W     = 17;
  localparam int STAT_W  = 2;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_EVAL   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_FIN
  } bcpe_state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic drop;
    logic out_load;
  } bcpe_cmd_t;

endpackage

/* src/bcpe_if.sv */
interface bcpe_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [bcpe_pkg::COORD_W-1:0] point_x;
  logic signed [bcpe_pkg::COORD_W-1:0] point_y;
  logic        [bcpe_pkg::T_W-1:0]     t_param;

  modport source (output valid, func, point_x, point_y, t_param, input ready);
  modport sink   (input valid, func, point_x, point_y, t_param, output ready);
endinterface

interface bcpe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bcpe_pkg::COORD_W-1:0] curve_x;
  logic signed [bcpe_pkg::COORD_W-1:0] curve_y;
  logic        [bcpe_pkg::STAT_W-1:0]  status;

  modport source (output valid, curve_x, curve_y, status, input ready);
  modport sink   (input valid, curve_x, curve_y, status, output ready);
endinterface

/* src/bcpe_datapath.sv */
module bcpe_datapath #(
  parameter int MAX_POINTS = 16,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bcpe_pkg::bcpe_cmd_t                 cmd,
  input  logic                                func,
  input  logic signed [bcpe_pkg::COORD_W-1:0] point_x,
  input  logic signed [bcpe_pkg::COORD_W-1:0] point_y,
  input  logic        [bcpe_pkg::T_W-1:0]     t_param,
  output logic        [CNT_W-1:0]             count,
  output logic signed [bcpe_pkg::COORD_W-1:0] curve_x,
  output logic signed [bcpe_pkg::COORD_W-1:0] curve_y,
  output logic        [bcpe_pkg::STAT_W-1:0]  status
);

  localparam int SECOND = (MAX_POINTS > 1) ? 1 : 0;
  localparam int CW     = bcpe_pkg::COORD_W;
  localparam int PW     = CW + 1 + bcpe_pkg::T_W + 1;

  logic signed [CW-1:0] store_x [MAX_POINTS];
  logic signed [CW-1:0] store_y [MAX_POINTS];
  logic signed [CW-1:0] q_x [MAX_POINTS];
  logic signed [CW-1:0] q_y [MAX_POINTS];
  logic [CNT_W-1:0]     q_cnt;
  logic [bcpe_pkg::T_W-1:0]    t_reg;
  logic                        eval_ok;
  logic [bcpe_pkg::STAT_W-1:0] res_st;
  logic signed [CW-1:0] m_ax, m_ay, m_px, m_py;
  logic                 wb_valid;

  logic                        full, empty, pop, is_eval;
  logic [bcpe_pkg::T_W-1:0]    t_sat;
  logic signed [CW:0]          diff_x, diff_y;
  logic signed [PW-1:0]        prod_x, prod_y;
  logic signed [CW-1:0]        wb_x, wb_y;
  logic [CNT_W-1:0]            push_pos;

  always_comb begin
    full     = (count == CNT_W'(MAX_POINTS));
    empty    = (count == '0);
    is_eval  = (func == bcpe_pkg::FUNC_EVAL);
    t_sat    = (t_param > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : t_param;
    pop      = cmd.issue | cmd.drop;
    diff_x   = {q_x[SECOND][CW-1], q_x[SECOND]} - {q_x[0][CW-1], q_x[0]};
    diff_y   = {q_y[SECOND][CW-1], q_y[SECOND]} - {q_y[0][CW-1], q_y[0]};
    prod_x   = PW'(diff_x) * PW'($signed({1'b0, t_reg}));
    prod_y   = PW'(diff_y) * PW'($signed({1'b0, t_reg}));
    // result is known to lie between its neighbours, so the low bits suffice
    wb_x     = m_ax + m_px;
    wb_y     = m_ay + m_py;
    push_pos = q_cnt - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      q_cnt    <= '0;
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= cmd.issue;
      if (cmd.accept && !is_eval && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.accept && is_eval) begin
        q_cnt <= count;
      end else begin
        q_cnt <= q_cnt - CNT_W'(pop) + CNT_W'(wb_valid);
      end
    end
  end

  // Append: write the next free slot.
  always_ff @(posedge clk) begin
    if (cmd.accept && !is_eval && !full) begin
      store_x[count[IDX_W-1:0]] <= point_x;
      store_y[count[IDX_W-1:0]] <= point_y;
    end
  end

  // Work queue: pop from the head, push interpolated values at the tail.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (cmd.accept && is_eval) begin
        q_x[k] <= store_x[k];
        q_y[k] <= store_y[k];
      end else if (wb_valid && push_pos[IDX_W-1:0] == IDX_W'(k)) begin
        q_x[k] <= wb_x;
        q_y[k] <= wb_y;
      end else if (pop && k < MAX_POINTS - 1) begin
        q_x[k] <= q_x[(k < MAX_POINTS - 1) ? k + 1 : k];
        q_y[k] <= q_y[(k < MAX_POINTS - 1) ? k + 1 : k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      m_ax <= q_x[0];
      m_ay <= q_y[0];
      m_px <= prod_x[CW+15:16];
      m_py <= prod_y[CW+15:16];
    end
    if (cmd.accept) begin
      t_reg   <= t_sat;
      eval_ok <= is_eval && !empty;
      if (is_eval) begin
        res_st <= empty ? bcpe_pkg::ST_EMPTY : bcpe_pkg::ST_OK;
      end else begin
        res_st <= full ? bcpe_pkg::ST_FULL : bcpe_pkg::ST_OK;
      end
    end
    if (cmd.out_load) begin
      curve_x <= eval_ok ? q_x[0] : '0;
      curve_y <= eval_ok ? q_y[0] : '0;
      status  <= res_st;
    end
  end

endmodule

/* src/bcpe_ctrl.sv */
module bcpe_ctrl #(
  parameter int CNT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 func,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  logic [CNT_W-1:0]     count,
  output bcpe_pkg::bcpe_cmd_t  cmd
);

  bcpe_pkg::bcpe_state_t state, state_next;
  logic [CNT_W-1:0] level, level_next;
  logic [CNT_W-1:0] step, step_next;
  logic             out_valid_next;
  logic             accept, last_step, slot_free;

  always_comb begin
    accept    = in_valid && (state == bcpe_pkg::S_IDLE);
    last_step = (step == level - CNT_W'(1));
    slot_free = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    level_next = level;
    step_next  = step;
    unique case (state)
      bcpe_pkg::S_IDLE: begin
        if (accept) begin
          level_next = count;
          step_next  = '0;
          if (func == bcpe_pkg::FUNC_EVAL && count > CNT_W'(1)) begin
            state_next = bcpe_pkg::S_STEP;
          end else begin
            state_next = bcpe_pkg::S_FIN;
          end
        end
      end
      bcpe_pkg::S_STEP: begin
        if (last_step) begin
          step_next = '0;
          if (level == CNT_W'(2)) begin
            state_next = bcpe_pkg::S_FIN;
          end else begin
            level_next = level - CNT_W'(1);
          end
        end else begin
          step_next = step + CNT_W'(1);
        end
      end
      bcpe_pkg::S_FIN: begin
        if (slot_free) begin
          state_next = bcpe_pkg::S_IDLE;
        end
      end
      default: state_next = bcpe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == bcpe_pkg::S_IDLE);
    cmd.accept   = accept;
    cmd.issue    = (state == bcpe_pkg::S_STEP) && !last_step;
    cmd.drop     = (state == bcpe_pkg::S_STEP) && last_step;
    cmd.out_load = (state == bcpe_pkg::S_FIN) && slot_free;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bcpe_pkg::S_IDLE;
      level     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      level     <= level_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/bezier_curve_point_eval.sv */
// Bezier curve point evaluator. An append item (func 0) stores one signed Q2.14
// control point, or reports status 1 when all MAX_POINTS slots are taken; an
// evaluate item (func 1) returns the curve point at t (Q1.16, values above 1.0
// are clamped) by de Casteljau, or status 2 with zero coordinates when no
// points are stored. Each item gives exactly one result. An append goes
// straight to the finish state; an evaluate over two or more points first
// steps through the levels of the work queue, the single multiplier per
// coordinate working one interpolation per cycle, and each level ends with a
// step that retires the leftover entry. The result is then loaded into the
// output register once that register is empty or being collected. A new item
// is taken in the cycle after the previous one has reached the output
// register, even if that result has not yet been collected. Points are stored
// only from reset onward; there is no clearing pass.
module bezier_curve_point_eval #(
  parameter int MAX_POINTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  bcpe_in_if.sink           in_ch,
  bcpe_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  bcpe_pkg::bcpe_cmd_t  cmd;
  logic [CNT_W-1:0]     count;

  bcpe_ctrl #(
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .func      (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .count     (count),
    .cmd       (cmd)
  );

  bcpe_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .func    (in_ch.func),
    .point_x (in_ch.point_x),
    .point_y (in_ch.point_y),
    .t_param (in_ch.t_param),
    .count   (count),
    .curve_x (out_ch.curve_x),
    .curve_y (out_ch.curve_y),
    .status  (out_ch.status)
  );

endmodule

/* src/bcpe_checker.sv */
`include "bezier_curve_point_eval_assert.svh"

module bcpe_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bcpe_pkg::COORD_W-1:0] curve_x,
  input logic signed [bcpe_pkg::COORD_W-1:0] curve_y,
  input logic        [bcpe_pkg::STAT_W-1:0]  status
);

  // hold a stalled result
  `BCPE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, $stable(curve_x) && $stable(curve_y) && $stable(status))

  // failed items carry zero coordinates
  `BCPE_ASSERT_IMPLY(a_fail_zero, clk, rst, out_valid && status != bcpe_pkg::ST_OK, curve_x == '0 && curve_y == '0)

  // one item in flight at a time
  `BCPE_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind bezier_curve_point_eval bcpe_checker u_bcpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .curve_x   (out_ch.curve_x),
  .curve_y   (out_ch.curve_y),
  .status    (out_ch.status)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int STORE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 1030;
  localparam int HOLD_CYCLES   = 1500;
  localparam int HOLD_AFTER    = 60;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int IDLE_PCT      = 9;
  localparam int QUIET_LO      = 400;
  localparam int QUIET_HI      = 600;

  typedef logic signed [bcpe_pkg::COORD_W-1:0] coord_t;
  typedef logic [bcpe_pkg::T_W-1:0]            tparam_t;

  typedef struct {
    logic    func;
    coord_t  point_x;
    coord_t  point_y;
    tparam_t t_param;
    bit      drain;
  } curve_req_t;

  typedef struct {
    coord_t                        curve_x;
    coord_t                        curve_y;
    logic [bcpe_pkg::STAT_W-1:0]   status;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcpe_in_if  req_ch ();
  bcpe_out_if rsp_ch ();

  bezier_curve_point_eval #(.MAX_POINTS(STORE_DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  curve_req_t   req_q[$];
  curve_point_t expected_pts[$];
  bit           drain_next;

  // Predictor copy of the control point list
  coord_t ctrl_x [STORE_DEPTH];
  coord_t ctrl_y [STORE_DEPTH];
  int     ctrl_count;

  int n_stored, n_dropped, n_evals, n_empty;
  int errors;
  int items_taken;
  int results_seen;
  int hold_cnt;
  bit hold_done;
  int cycle_cnt;

  function automatic coord_t casteljau_axis(input bit y_axis, input int n, input tparam_t t);
    longint w[STORE_DEPTH];
    longint d;
    int lvl;
    int i;
    for (i = 0; i < n; i++)
      w[i] = y_axis ? longint'(ctrl_y[i]) : longint'(ctrl_x[i]);
    for (lvl = n; lvl > 1; lvl--)
      for (i = 0; i + 1 < lvl; i++) begin
        d = (w[i+1] - w[i]) * longint'(t);
        w[i] = w[i] + (d >>> 16);
      end
    return coord_t'(w[0][bcpe_pkg::COORD_W-1:0]);
  endfunction

  task automatic predict_point(input curve_req_t req);
    curve_point_t r;
    tparam_t t_eff;
    r.curve_x = '0;
    r.curve_y = '0;
    r.status  = bcpe_pkg::ST_OK;
    if (req.func == bcpe_pkg::FUNC_APPEND) begin
      if (ctrl_count < STORE_DEPTH) begin
        ctrl_x[ctrl_count] = req.point_x;
        ctrl_y[ctrl_count] = req.point_y;
        ctrl_count++;
        n_stored++;
      end else begin
        r.status = bcpe_pkg::ST_FULL;
        n_dropped++;
      end
    end else begin
      t_eff = (req.t_param > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : req.t_param;
      if (ctrl_count == 0) begin
        r.status = bcpe_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        r.curve_x = casteljau_axis(1'b0, ctrl_count, t_eff);
        r.curve_y = casteljau_axis(1'b1, ctrl_count, t_eff);
        n_evals++;
      end
    end
    expected_pts = {expected_pts, r};
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tparam_t rand_t();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return bcpe_pkg::T_ONE;
      2:       return tparam_t'($urandom_range(65537, 131071));
      default: return tparam_t'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic push_append(input coord_t x, input coord_t y);
    curve_req_t req;
    req.func    = bcpe_pkg::FUNC_APPEND;
    req.point_x = x;
    req.point_y = y;
    req.t_param = tparam_t'($urandom);
    req.drain   = drain_next;
    drain_next  = 1'b0;
    req_q = {req_q, req};
  endtask

  task automatic push_eval(input tparam_t t);
    curve_req_t req;
    req.func    = bcpe_pkg::FUNC_EVAL;
    req.point_x = coord_t'($urandom);
    req.point_y = coord_t'($urandom);
    req.t_param = t;
    req.drain   = drain_next;
    drain_next  = 1'b0;
    req_q = {req_q, req};
  endtask

  // Driver: hold the item until its transfer, then offer the next one
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_point(req_q.pop_front());
        items_taken <= items_taken + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        offer = req_q.size() != 0;
        if (offer && (items_taken < QUIET_LO || items_taken >= QUIET_HI)
            && $urandom_range(0, 99) < IDLE_PCT)
          offer = 1'b0;
        if (offer && req_q[0].drain && expected_pts.size() != 0)
          offer = 1'b0;
        if (offer) begin
          req_ch.valid   <= 1'b1;
          req_ch.func    <= req_q[0].func;
          req_ch.point_x <= req_q[0].point_x;
          req_ch.point_y <= req_q[0].point_y;
          req_ch.t_param <= req_q[0].t_param;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result side so that the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    curve_point_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_pts.size() == 0) begin
          $error("unexpected result: curve_x %0d curve_y %0d status %0d",
                 rsp_ch.curve_x, rsp_ch.curve_y, rsp_ch.status);
          errors++;
        end else begin
          want = expected_pts.pop_front();
          if (rsp_ch.curve_x !== want.curve_x) begin
            $error("curve_x: expected %0d, got %0d", want.curve_x, rsp_ch.curve_x);
            errors++;
          end
          if (rsp_ch.curve_y !== want.curve_y) begin
            $error("curve_y: expected %0d, got %0d", want.curve_y, rsp_ch.curve_y);
            errors++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            errors++;
          end
        end
      end
      rsp_ch.ready <= (hold_cnt == 0) &&
                      ((results_seen >= QUIET_LO && results_seen < QUIET_HI) ||
                       $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bezier_curve_point_eval: mismatch");
      $finish;
    end
  end

  initial begin
    int planned;
    int k;
    int done;
    req_ch.valid   = 1'b0;
    req_ch.func    = bcpe_pkg::FUNC_APPEND;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    req_ch.t_param = '0;
    rsp_ch.ready   = 1'b0;
    drain_next     = 1'b0;
    ctrl_count     = 0;
    n_stored = 0; n_dropped = 0; n_evals = 0; n_empty = 0;
    errors = 0; items_taken = 0; results_seen = 0; cycle_cnt = 0;

    // Empty store, single point, then two and four points at the edges of t
    push_eval('0);
    push_eval(17'h1FFFF);
    push_append(16'sh8000, 16'sh7FFF);
    push_eval('0);
    push_eval(bcpe_pkg::T_ONE);
    push_eval(17'h1FFFF);
    push_append(16'sh7FFF, 16'sh8000);
    push_eval('0);
    push_eval(17'h00001);
    push_eval(17'h08000);
    push_eval(bcpe_pkg::T_ONE);
    push_eval(17'h10001);
    push_append(16'sh0000, -16'sd1);
    push_append(-16'sd1, 16'sh0000);
    push_eval(17'h0FFFF);
    push_eval(17'h04000);
    planned = 4;

    // Fill the store, evaluating at every degree on the way
    drain_next = 1'b1;
    done = 0;
    while (planned < STORE_DEPTH) begin
      push_append(rand_coord(), rand_coord());
      planned++;
      done++;
      for (k = $urandom_range(1, 3); k > 0; k--) begin
        push_eval(rand_t());
        done++;
      end
    end
    push_append(rand_coord(), rand_coord());
    push_append(rand_coord(), rand_coord());
    done += 2;

    // Full store: mostly evaluations, some dropped appends
    while (done < RANDOM_ITEMS) begin
      if (done == RANDOM_ITEMS / 2)
        drain_next = 1'b1;
      if ($urandom_range(0, 99) < 12)
        push_append(rand_coord(), rand_coord());
      else
        push_eval(rand_t());
      done++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d appends stored and %0d dropped on a full store,",
             n_stored, n_dropped);
    $display("%0d evaluations over 1 to %0d points and %0d on an empty store",
             n_evals, STORE_DEPTH, n_empty);
    if (errors == 0)
      $display("bezier_curve_point_eval: match");
    else
      $display("bezier_curve_point_eval: mismatch");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/bcpe_pkg.sv
src/bcpe_if.sv
src/bcpe_datapath.sv
src/bcpe_ctrl.sv
src/bezier_curve_point_eval.sv
src/bcpe_checker.sv
dv/tb.sv
